// ----- src/cpe_pkg.sv -----
// shared types and constants for the parameter extractor
package cpe_pkg;

  localparam int FRAC = 52;
  localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AB;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOVALID = 3'd1;
  localparam logic [2:0] ST_NOZERO  = 3'd2;
  localparam logic [2:0] ST_ALLZERO = 3'd3;
  localparam logic [2:0] ST_NOSIGMA = 3'd4;

  // column totals handed from the accumulator to the math engine
  typedef struct packed {
    logic [16:0] valid_count;
    logic [16:0] zero_count;
    logic [39:0] sample_sum;
    logic [63:0] square_sum;
  } col_t;

endpackage

// ----- src/cpln_parameter_extractor_core.sv -----
// top level of the compound-poisson-lognormal parameter extractor
// channel | direction | ports
// in      | input     | in_valid, in_ready, in_sample, in_valid_mask, in_last
// out     | output    | out_valid, out_ready, out_lambda_out, out_mu_out, out_sigma_out, out_status
// samples are taken one per cycle while in_ready is high; one column total waits in a single-entry buffer
// the math engine runs each column through five log2 passes, five multiplies and a sqrt;
// columns that fail the count checks go straight to the result
// a new column can fill while the engine works; input stalls only if a second total is waiting
// synchronous active-low reset clears counters and control
module cpln_parameter_extractor_core #(
  parameter int MAX_SAMPLES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [23:0] in_sample,
  input  logic        in_valid_mask,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_lambda_out,
  output logic [31:0] out_mu_out,
  output logic [31:0] out_sigma_out,
  output logic [2:0]  out_status
);

  logic          col_valid, col_ready;
  cpe_pkg::col_t col_data;

  cpe_accum #(.MAX_SAMPLES(MAX_SAMPLES)) u_accum (
    .clk, .rst_n, .in_valid, .in_ready, .in_sample, .in_valid_mask, .in_last,
    .col_valid, .col_ready, .col_data
  );

  cpe_math u_math (
    .clk, .rst_n, .col_valid, .col_ready, .col_data,
    .out_valid, .out_ready, .out_lambda_out, .out_mu_out, .out_sigma_out, .out_status
  );

endmodule

// ----- src/cpe_accum.sv -----
// front end: accumulates masked samples of one column
module cpe_accum #(
  parameter int MAX_SAMPLES = 65536
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [23:0]    in_sample,
  input  logic           in_valid_mask,
  input  logic           in_last,
  output logic           col_valid,
  input  logic           col_ready,
  output cpe_pkg::col_t  col_data
);

  localparam logic [16:0] MaxCnt = 17'(MAX_SAMPLES);

  logic [16:0] vc_r, zc_r;
  logic [39:0] ss_r;
  logic [63:0] qs_r;
  logic        hold_r;
  cpe_pkg::col_t col_r;
  logic take;
  logic [16:0] vc_nxt, zc_nxt;
  logic [39:0] ss_nxt;
  logic [63:0] qs_nxt;

  assign in_ready  = !hold_r || col_ready;
  assign take      = in_valid && in_ready;
  assign col_valid = hold_r;
  assign col_data  = col_r;

  always_comb begin
    vc_nxt = vc_r;
    zc_nxt = zc_r;
    ss_nxt = ss_r;
    qs_nxt = qs_r;
    if (in_valid_mask && vc_r < MaxCnt) begin
      vc_nxt = vc_r + 17'd1;
      if (in_sample == 24'd0) zc_nxt = zc_r + 17'd1;
      ss_nxt = ss_r + {16'd0, in_sample};
      qs_nxt = qs_r + {16'd0, 48'(in_sample) * 48'(in_sample)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= '0; zc_r <= '0; ss_r <= '0; qs_r <= '0; hold_r <= 1'b0;
    end else begin
      if (hold_r && col_ready) hold_r <= 1'b0;
      if (take) begin
        if (in_last) begin
          col_r.valid_count <= vc_nxt;
          col_r.zero_count  <= zc_nxt;
          col_r.sample_sum  <= ss_nxt;
          col_r.square_sum  <= qs_nxt;
          hold_r <= 1'b1;
          vc_r <= '0; zc_r <= '0; ss_r <= '0; qs_r <= '0;
        end else begin
          vc_r <= vc_nxt; zc_r <= zc_nxt; ss_r <= ss_nxt; qs_r <= qs_nxt;
        end
      end
    end
  end

endmodule

// ----- src/cpe_math.sv -----
// back end: sequenced log2 / ln / sqrt engine for one column result
module cpe_math (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           col_valid,
  output logic           col_ready,
  input  cpe_pkg::col_t  col_data,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [31:0]    out_lambda_out,
  output logic [31:0]    out_mu_out,
  output logic [31:0]    out_sigma_out,
  output logic [2:0]     out_status
);

  typedef enum logic [4:0] {
    S_IDLE, S_CHK, S_LV, S_LZ, S_LAM, S_LAMLN, S_VQ, S_S2, S_DIFF,
    S_LLAM, S_LS, S_LD, S_X2, S_MU, S_MULN, S_SGLN, S_SQRT, S_DONE
  } state_t;

  state_t        st_r, ret_r;
  cpe_pkg::col_t c_r;
  // shared log2 unit, each squaring step built from four 32x32 partial products
  logic [127:0]  lx_r;
  logic [63:0]   lm_r, lf_r;
  logic [5:0]    lcnt_r;
  logic [7:0]    lp_r;
  logic          lbusy_r;
  logic [1:0]    lsub_r;
  logic [127:0]  lsq_r;
  // shared 64x64 multiplier, one 32x32 partial product per cycle
  logic [63:0]   ma_r, mb_r;
  logic [127:0]  mp_r;
  logic [2:0]    mcnt_r;
  logic          mbusy_r;
  logic signed [63:0] l2v_r, l2z_r, lam_r, l2lam_r, l2mean_r, l2var_r, x2_r, tmp_r;
  logic [127:0]  vq_r, d_r;
  logic [63:0]   sq_n_r, sq_res_r, sq_bit_r;
  logic [31:0]   lamq_r, muq_r, sgq_r;
  logic [2:0]    stat_r;
  logic          neg_r;
  logic          ov_r;

  logic [127:0]  msq;
  logic [63:0]   lm_next;
  logic [7:0]    top;
  logic [63:0]   pp;
  logic [31:0]   pa, pb;
  logic [63:0]   opa, opb;
  logic [1:0]    psel, pdig;
  logic [127:0]  ppsh;
  logic [63:0]   sq_sum;

  function automatic logic [31:0] to_q24(input logic signed [63:0] v);
    logic [63:0] u, r;
    u = v[63] ? 64'(-v) : 64'(v);
    r = (u + (64'd1 << (cpe_pkg::FRAC - 25))) >> (cpe_pkg::FRAC - 24);
    if (!v[63]) return (r > 64'h7FFFFFFF) ? 32'h7FFFFFFF : r[31:0];
    if (r > 64'h80000000) r = 64'h80000000;
    return 32'(64'd0 - r);
  endfunction

  // position of the top set bit of the log operand
  always_comb begin
    top = '0;
    for (int i = 0; i < 128; i++) if (lx_r[i]) top = 8'(i);
  end

  assign psel    = lbusy_r ? lsub_r : mcnt_r[1:0];
  assign opa     = lbusy_r ? lm_r : ma_r;
  assign opb     = lbusy_r ? lm_r : mb_r;
  assign pa      = psel[1] ? opa[63:32] : opa[31:0];
  assign pb      = psel[0] ? opb[63:32] : opb[31:0];
  assign pp      = 64'(pa) * 64'(pb);
  assign pdig    = {1'b0, psel[1]} + {1'b0, psel[0]};
  assign ppsh    = {64'd0, pp} << {pdig, 5'd0};
  assign msq     = lsq_r + ppsh;
  assign lm_next = {msq[125:64], msq[63:62]};
  assign sq_sum  = sq_res_r + sq_bit_r;

  assign col_ready      = (st_r == S_IDLE);
  assign out_valid      = (st_r == S_DONE);
  assign out_lambda_out = lamq_r;
  assign out_mu_out     = muq_r;
  assign out_sigma_out  = sgq_r;
  assign out_status     = stat_r;

  logic [127:0] shx;
  always_comb begin
    if (top > 8'd62) shx = lx_r >> (top - 8'd62);
    else shx = lx_r << (8'd62 - top);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; lbusy_r <= 1'b0; mbusy_r <= 1'b0;
      ret_r <= S_IDLE;
    end else if (lbusy_r) begin
      if (lcnt_r == 6'd0) begin
        lm_r <= shx[63:0];
        lp_r <= top;
        lf_r <= '0;
        lsq_r <= '0;
        lsub_r <= '0;
        lcnt_r <= 6'd1;
      end else if (lsub_r != 2'd3) begin
        lsq_r <= msq;
        lsub_r <= lsub_r + 2'd1;
      end else begin
        if (lm_next[63]) lm_r <= {1'b0, lm_next[63:1]};
        else lm_r <= lm_next;
        lf_r <= {lf_r[62:0], lm_next[63]};
        lsq_r <= '0;
        lsub_r <= '0;
        if (lcnt_r == 6'(cpe_pkg::FRAC)) begin
          lbusy_r <= 1'b0;
          st_r <= ret_r;
        end
        lcnt_r <= lcnt_r + 6'd1;
      end
    end else if (mbusy_r) begin
      mp_r <= mp_r + ppsh;
      if (mcnt_r == 3'd3) begin
        mbusy_r <= 1'b0;
        st_r <= ret_r;
      end
      mcnt_r <= mcnt_r + 3'd1;
    end else begin
      case (st_r)
        S_IDLE: if (col_valid) begin
          c_r <= col_data; st_r <= S_CHK;
        end
        S_CHK: begin
          lamq_r <= '0; muq_r <= '0; sgq_r <= '0; stat_r <= cpe_pkg::ST_OK;
          if (c_r.valid_count == 17'd0) begin
            stat_r <= cpe_pkg::ST_NOVALID; st_r <= S_DONE;
          end else if (c_r.zero_count == 17'd0) begin
            stat_r <= cpe_pkg::ST_NOZERO; st_r <= S_DONE;
          end else if (c_r.zero_count >= c_r.valid_count || c_r.sample_sum == 40'd0) begin
            stat_r <= cpe_pkg::ST_ALLZERO; st_r <= S_DONE;
          end else begin
            lx_r <= {111'd0, c_r.valid_count}; lcnt_r <= '0; lbusy_r <= 1'b1;
            ret_r <= S_LV; st_r <= S_LV;
          end
        end
        S_LV: begin
          l2v_r <= {{48{1'b0}}, 8'd0, lp_r} <<< cpe_pkg::FRAC | 64'(lf_r);
          lx_r <= {111'd0, c_r.zero_count}; lcnt_r <= '0; lbusy_r <= 1'b1;
          ret_r <= S_LZ; st_r <= S_LZ;
        end
        S_LZ: begin
          l2z_r <= ($signed({56'd0, lp_r}) <<< cpe_pkg::FRAC) | 64'(lf_r);
          st_r <= S_LAM;
        end
        S_LAM: begin
          tmp_r <= l2v_r - l2z_r;
          ma_r <= 64'(l2v_r - l2z_r); mb_r <= cpe_pkg::LN2_Q64;
          mp_r <= '0; mcnt_r <= '0; mbusy_r <= 1'b1;
          ret_r <= S_LAMLN; st_r <= S_LAMLN;
        end
        S_LAMLN: begin
          if (mp_r[127:64] < 64'd1) lam_r <= 64'sd1;
          else lam_r <= $signed(mp_r[127:64]);
          lamq_r <= to_q24((mp_r[127:64] < 64'd1) ? 64'sd1 : $signed(mp_r[127:64]));
          ma_r <= 64'(c_r.valid_count); mb_r <= c_r.square_sum;
          mp_r <= '0; mcnt_r <= '0; mbusy_r <= 1'b1;
          ret_r <= S_VQ; st_r <= S_VQ;
        end
        S_VQ: begin
          vq_r <= mp_r;
          ma_r <= 64'(c_r.sample_sum); mb_r <= 64'(c_r.sample_sum);
          mp_r <= '0; mcnt_r <= '0; mbusy_r <= 1'b1;
          ret_r <= S_S2; st_r <= S_S2;
        end
        S_S2: begin
          ov_r <= (vq_r <= mp_r);
          d_r <= vq_r - mp_r;
          st_r <= S_DIFF;
        end
        S_DIFF: begin
          if (ov_r) begin
            stat_r <= cpe_pkg::ST_NOSIGMA; st_r <= S_DONE;
          end else begin
            lx_r <= {64'd0, lam_r}; lcnt_r <= '0; lbusy_r <= 1'b1;
            ret_r <= S_LLAM; st_r <= S_LLAM;
          end
        end
        S_LLAM: begin
          l2lam_r <= ($signed({56'd0, lp_r}) - 64'sd52 <<< cpe_pkg::FRAC) | 64'(lf_r);
          lx_r <= {88'd0, c_r.sample_sum}; lcnt_r <= '0; lbusy_r <= 1'b1;
          ret_r <= S_LS; st_r <= S_LS;
        end
        S_LS: begin
          l2mean_r <= (($signed({56'd0, lp_r}) - 64'sd8) <<< cpe_pkg::FRAC)
                      + 64'(lf_r) - l2v_r;
          lx_r <= d_r; lcnt_r <= '0; lbusy_r <= 1'b1;
          ret_r <= S_LD; st_r <= S_LD;
        end
        S_LD: begin
          l2var_r <= (($signed({56'd0, lp_r}) - 64'sd16) <<< cpe_pkg::FRAC)
                     + 64'(lf_r) - (l2v_r <<< 1);
          st_r <= S_X2;
        end
        S_X2: begin
          x2_r <= l2var_r + l2lam_r - (l2mean_r <<< 1);
          tmp_r <= (l2mean_r <<< 3) - (l2var_r <<< 1) - (l2lam_r * 64'sd6);
          st_r <= S_MU;
        end
        S_MU: begin
          if (x2_r < 0) begin
            stat_r <= cpe_pkg::ST_NOSIGMA; st_r <= S_DONE;
          end else begin
            neg_r <= (tmp_r / 64'sd4) < 0;
            ma_r <= (tmp_r / 64'sd4) < 0 ? 64'(-(tmp_r / 64'sd4)) : 64'(tmp_r / 64'sd4);
            mb_r <= cpe_pkg::LN2_Q64;
            mp_r <= '0; mcnt_r <= '0; mbusy_r <= 1'b1;
            ret_r <= S_MULN; st_r <= S_MULN;
          end
        end
        S_MULN: begin
          muq_r <= to_q24(neg_r ? -$signed(mp_r[127:64]) : $signed(mp_r[127:64]));
          ma_r <= 64'(x2_r); mb_r <= cpe_pkg::LN2_Q64;
          mp_r <= '0; mcnt_r <= '0; mbusy_r <= 1'b1;
          ret_r <= S_SGLN; st_r <= S_SGLN;
        end
        S_SGLN: begin
          sq_n_r <= mp_r[127:64]; sq_res_r <= '0; sq_bit_r <= 64'd1 << 62;
          st_r <= S_SQRT;
        end
        S_SQRT: begin
          if (sq_bit_r == 64'd0) begin
            sgq_r <= 32'((sq_res_r + 64'd2) >> 2);
            st_r <= S_DONE;
          end else begin
            if (sq_n_r >= sq_sum) begin
              sq_n_r <= sq_n_r - sq_sum;
              sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
            end else begin
              sq_res_r <= sq_res_r >> 1;
            end
            sq_bit_r <= sq_bit_r >> 2;
          end
        end
        S_DONE: if (out_ready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/cpe_checker.sv -----
// port-level assertions for the parameter extractor
module cpe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_lambda_out,
  input logic [31:0] out_mu_out,
  input logic [31:0] out_sigma_out,
  input logic [2:0]  out_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result dropped while stalled");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= cpe_pkg::ST_NOSIGMA)
    else $error("bad status");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != cpe_pkg::ST_OK && out_status != cpe_pkg::ST_NOSIGMA |->
    out_lambda_out == 32'd0 && out_mu_out == 32'd0 && out_sigma_out == 32'd0)
    else $error("nonzero values with error status");

  a_in_ready_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid |-> !$isunknown(in_ready))
    else $error("unknown input ready");

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind cpln_parameter_extractor_core cpe_checker u_cpe_checker (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
  .out_lambda_out, .out_mu_out, .out_sigma_out, .out_status
);
